>>> design/fmtp_pkg.sv
// shared constants, types and command/status bundles for the format printer
package fmtp_pkg;

    localparam int unsigned MAX_FIELD_WIDTH = 64;
    localparam int unsigned WIDTH_BITS      = 7;
    localparam int unsigned CHAR_BITS       = 8;
    localparam int unsigned ARG_BITS        = 32;
    localparam int unsigned NUM_DIGITS      = 10;
    localparam int unsigned HEX_DIGITS      = 8;
    localparam int unsigned S_TDATA_BITS    = 40;
    localparam int unsigned M_TDATA_BITS    = 8;

    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_LOWER_D = 8'h64;
    localparam logic [7:0] CH_LOWER_C = 8'h63;
    localparam logic [3:0] NIBBLE_MASK = 4'hF;
    localparam logic [3:0] DEC_RADIX   = 4'd10;

    // 2^35 / 10 rounded up, exact quotient for any 32-bit value
    localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
    localparam int unsigned RECIP_SHIFT = 35;

    typedef enum logic [2:0] {
        KIND_PERCENT,
        KIND_FLAG,
        KIND_DIGIT,
        KIND_HEX,
        KIND_DEC,
        KIND_SINGLE
    } kind_t;

    typedef enum logic [2:0] {
        PARSE_HOLD,
        PARSE_PERCENT,
        PARSE_FLAG,
        PARSE_DIGIT,
        PARSE_CLEAR
    } parse_op_t;

    typedef enum logic [1:0] {
        EMIT_PAD,
        EMIT_SIGN,
        EMIT_DIGIT,
        EMIT_SINGLE
    } emit_sel_t;

    typedef struct packed {
        logic      capture;
        parse_op_t parse_op;
        logic      load_hex;
        logic      load_dec;
        logic      mul;
        logic      digit;
        logic      load_pad;
        logic      emit;
        emit_sel_t emit_sel;
        logic      emit_last;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  out_free;
        logic  pad_zero;
        logic  neg;
        logic  digit_done;
        logic  idx_one;
    } status_t;

    function automatic logic [7:0] nibble_to_ascii(input logic [3:0] d);
        logic [7:0] r;
        if (d < DEC_RADIX) begin
            r = CH_ZERO + {4'd0, d};
        end else begin
            r = CH_UPPER_A + {4'd0, d - DEC_RADIX};
        end
        return r;
    endfunction

endpackage

>>> design/fmtp_ctrl.sv
// controller state machine sequencing decode, digit conversion and character output
module fmtp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  fmtp_pkg::status_t status,
    output fmtp_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL,
        ST_DIGIT,
        ST_PADSET,
        ST_PAD,
        ST_TEXT,
        ST_SINGLE
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.parse_op  = fmtp_pkg::PARSE_HOLD;
        cmd.emit_sel  = fmtp_pkg::EMIT_PAD;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (status.kind)
                    fmtp_pkg::KIND_PERCENT: begin
                        cmd.parse_op = fmtp_pkg::PARSE_PERCENT;
                        state_next   = ST_IDLE;
                    end
                    fmtp_pkg::KIND_FLAG: begin
                        cmd.parse_op = fmtp_pkg::PARSE_FLAG;
                        state_next   = ST_IDLE;
                    end
                    fmtp_pkg::KIND_DIGIT: begin
                        cmd.parse_op = fmtp_pkg::PARSE_DIGIT;
                        state_next   = ST_IDLE;
                    end
                    fmtp_pkg::KIND_HEX: begin
                        cmd.load_hex = 1'b1;
                        state_next   = ST_PADSET;
                    end
                    fmtp_pkg::KIND_DEC: begin
                        cmd.load_dec = 1'b1;
                        state_next   = ST_MUL;
                    end
                    default: begin
                        state_next = ST_SINGLE;
                    end
                endcase
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DIGIT;
            end
            ST_DIGIT: begin
                cmd.digit  = 1'b1;
                state_next = status.digit_done ? ST_PADSET : ST_MUL;
            end
            ST_PADSET: begin
                cmd.load_pad = 1'b1;
                state_next   = ST_PAD;
            end
            ST_PAD: begin
                // padding first, then the sign, both never the final character
                if (!status.pad_zero) begin
                    if (status.out_free) begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = fmtp_pkg::EMIT_PAD;
                    end
                end else if (status.neg) begin
                    if (status.out_free) begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = fmtp_pkg::EMIT_SIGN;
                        state_next   = ST_TEXT;
                    end
                end else begin
                    state_next = ST_TEXT;
                end
            end
            ST_TEXT: begin
                if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = fmtp_pkg::EMIT_DIGIT;
                    cmd.emit_last = status.idx_one;
                    if (status.idx_one) begin
                        cmd.parse_op = fmtp_pkg::PARSE_CLEAR;
                        state_next   = ST_IDLE;
                    end
                end
            end
            ST_SINGLE: begin
                if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = fmtp_pkg::EMIT_SINGLE;
                    cmd.emit_last = 1'b1;
                    cmd.parse_op  = fmtp_pkg::PARSE_CLEAR;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/fmtp_dp.sv
// datapath: parse state, digit generation by reciprocal multiply, output register
module fmtp_dp (
    input  logic              aclk,
    input  logic              aresetn,
    input  fmtp_pkg::cmd_t    cmd,
    output fmtp_pkg::status_t status,
    input  logic [39:0]       in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_char,
    output logic              out_last
);

    localparam logic [1:0] MODE_PLAIN  = 2'd0;
    localparam logic [1:0] MODE_PCT    = 2'd1;
    localparam logic [1:0] MODE_WIDTH  = 2'd2;

    logic [7:0]  char_reg;
    logic [31:0] arg_reg;
    logic [1:0]  mode_reg;
    logic        zpad_reg;
    logic [6:0]  width_reg;
    logic [31:0] mag_reg;
    logic [28:0] quot_reg;
    logic        neg_reg;
    logic [3:0]  dig_reg [fmtp_pkg::NUM_DIGITS];
    logic [3:0]  nd_reg;
    logic [3:0]  idx_reg;
    logic [6:0]  pad_reg;
    logic        out_valid_reg;
    logic [7:0]  out_char_reg;
    logic        out_last_reg;

    logic        in_spec;
    logic        is_digit;
    fmtp_pkg::kind_t kind_sel;
    logic [9:0]  width_sum;
    logic [6:0]  width_next;
    logic [63:0] product;
    logic [31:0] rem_full;
    logic [4:0]  text_len;
    logic [3:0]  idx_less;
    logic [7:0]  single_char;
    logic [7:0]  emit_char;

    assign in_spec  = (mode_reg == MODE_PCT) || (mode_reg == MODE_WIDTH);
    assign is_digit = (char_reg >= fmtp_pkg::CH_ZERO) && (char_reg <= fmtp_pkg::CH_NINE);

    always_comb begin
        if (mode_reg == MODE_PCT && char_reg == fmtp_pkg::CH_ZERO) begin
            kind_sel = fmtp_pkg::KIND_FLAG;
        end else if (in_spec && is_digit) begin
            kind_sel = fmtp_pkg::KIND_DIGIT;
        end else if (in_spec && char_reg == fmtp_pkg::CH_LOWER_X) begin
            kind_sel = fmtp_pkg::KIND_HEX;
        end else if (in_spec && char_reg == fmtp_pkg::CH_LOWER_D) begin
            kind_sel = fmtp_pkg::KIND_DEC;
        end else if (!in_spec && char_reg == fmtp_pkg::CH_PERCENT) begin
            kind_sel = fmtp_pkg::KIND_PERCENT;
        end else begin
            kind_sel = fmtp_pkg::KIND_SINGLE;
        end
    end

    // width accumulates decimal digits and saturates at the field limit
    assign width_sum  = 10'(width_reg) * 10'd10 + {6'd0, char_reg[3:0]};
    assign width_next = (width_sum > 10'(fmtp_pkg::MAX_FIELD_WIDTH))
                        ? 7'(fmtp_pkg::MAX_FIELD_WIDTH) : width_sum[6:0];

    assign product  = mag_reg * fmtp_pkg::RECIP_TEN;
    assign rem_full = mag_reg - ({3'd0, quot_reg} << 3) - ({3'd0, quot_reg} << 1);
    assign text_len = {1'b0, nd_reg} + {4'd0, neg_reg};
    assign idx_less = idx_reg - 4'd1;

    assign single_char = (in_spec && char_reg == fmtp_pkg::CH_LOWER_C) ? arg_reg[7:0]
                                                                       : char_reg;

    always_comb begin
        case (cmd.emit_sel)
            fmtp_pkg::EMIT_PAD:   emit_char = zpad_reg ? fmtp_pkg::CH_ZERO : fmtp_pkg::CH_SPACE;
            fmtp_pkg::EMIT_SIGN:  emit_char = fmtp_pkg::CH_MINUS;
            fmtp_pkg::EMIT_DIGIT: emit_char = fmtp_pkg::nibble_to_ascii(dig_reg[idx_less]);
            default:              emit_char = single_char;
        endcase
    end

    assign status.kind       = kind_sel;
    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.pad_zero   = (pad_reg == 7'd0);
    assign status.neg        = neg_reg;
    assign status.digit_done = (quot_reg == 29'd0) ||
                               (nd_reg == 4'(fmtp_pkg::NUM_DIGITS - 1));
    assign status.idx_one    = (idx_reg == 4'd1);

    // parse state and output handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_PLAIN;
            zpad_reg      <= 1'b0;
            width_reg     <= 7'd0;
            out_valid_reg <= 1'b0;
        end else begin
            case (cmd.parse_op)
                fmtp_pkg::PARSE_PERCENT: begin
                    mode_reg  <= MODE_PCT;
                    zpad_reg  <= 1'b0;
                    width_reg <= 7'd0;
                end
                fmtp_pkg::PARSE_FLAG: begin
                    mode_reg <= MODE_WIDTH;
                    zpad_reg <= 1'b1;
                end
                fmtp_pkg::PARSE_DIGIT: begin
                    mode_reg  <= MODE_WIDTH;
                    width_reg <= width_next;
                end
                fmtp_pkg::PARSE_CLEAR: begin
                    mode_reg  <= MODE_PLAIN;
                    zpad_reg  <= 1'b0;
                    width_reg <= 7'd0;
                end
                default: begin
                end
            endcase
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            char_reg <= in_data[7:0];
            arg_reg  <= in_data[39:8];
        end
        if (cmd.load_hex) begin
            for (int i = 0; i < fmtp_pkg::HEX_DIGITS; i++) begin
                dig_reg[i] <= arg_reg[i*4 +: 4] & fmtp_pkg::NIBBLE_MASK;
            end
            nd_reg  <= 4'(fmtp_pkg::HEX_DIGITS);
            neg_reg <= 1'b0;
        end
        if (cmd.load_dec) begin
            neg_reg <= arg_reg[31];
            mag_reg <= arg_reg[31] ? (32'd0 - arg_reg) : arg_reg;
            nd_reg  <= 4'd0;
        end
        if (cmd.mul) begin
            quot_reg <= product[63:fmtp_pkg::RECIP_SHIFT];
        end
        if (cmd.digit) begin
            dig_reg[nd_reg] <= rem_full[3:0];
            nd_reg          <= nd_reg + 4'd1;
            mag_reg         <= {3'd0, quot_reg};
        end
        if (cmd.load_pad) begin
            pad_reg <= (width_reg > 7'(text_len)) ? (width_reg - 7'(text_len)) : 7'd0;
            idx_reg <= nd_reg;
        end
        if (cmd.emit) begin
            out_char_reg <= emit_char;
            out_last_reg <= cmd.emit_last;
            if (cmd.emit_sel == fmtp_pkg::EMIT_PAD) begin
                pad_reg <= pad_reg - 7'd1;
            end
            if (cmd.emit_sel == fmtp_pkg::EMIT_DIGIT) begin
                idx_reg <= idx_less;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

endmodule

>>> design/format_string_integer_printer.sv
// a plain or echoed character passes through the decode and single-character states to the output register
// one request at a time; prefix, flag and width requests only update the parse state,
// hex and decimal requests load their digits, set the padding, then emit pad, sign and digits,
// and an output stall holds the sequencer until the character is taken
// decimal digits come from a reciprocal multiply, alternating multiply and digit states
// reset: synchronous aresetn clears the parse state, the sequencer and m_tvalid
module format_string_integer_printer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] format_char, [39:8] arg_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_char
    output logic        m_tlast
);

    fmtp_pkg::cmd_t    cmd;
    fmtp_pkg::status_t status;

    fmtp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fmtp_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

>>> design/fmtp_checker.sv
// port-level checks on the format printer, bound to the top level
module fmtp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);

    // a stalled character holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output changed");

    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // one request at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // no new request while the current run is unfinished
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("request taken mid-run");

endmodule

bind format_string_integer_printer fmtp_checker u_fmtp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
